### src/plb_pkg.sv
`timescale 1ns / 1ps

package plb_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 4;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_POP     = 3'd2,
    CMD_DEQUEUE = 3'd3,
    CMD_DELETE  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE
  } op_e;

  // Broadcast from the control unit to every cell.
  typedef struct packed {
    op_e                    op;
    logic [IDX_W-1:0]       at;
    logic signed [VAL_W-1:0] value;
  } ctl_t;

endpackage

### src/plb_cell.sv
`timescale 1ns / 1ps

module plb_cell (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  plb_pkg::ctl_t                   ctl_i,
  input  logic [plb_pkg::IDX_W-1:0]       idx_i,
  input  logic signed [plb_pkg::VAL_W-1:0] left_i,
  input  logic signed [plb_pkg::VAL_W-1:0] right_i,
  output logic signed [plb_pkg::VAL_W-1:0] q_o,
  output logic                            hit_o
);
  import plb_pkg::*;

  logic signed [VAL_W-1:0] entry_q, entry_d;

  assign hit_o = (idx_i == ctl_i.at);

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      OP_INSERT: begin
        if (idx_i == ctl_i.at) entry_d = ctl_i.value;
        else if (idx_i > ctl_i.at) entry_d = left_i;
      end
      OP_REMOVE: begin
        if (idx_i >= ctl_i.at) entry_d = right_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) entry_q <= entry_d;
  end

  assign q_o = entry_q;

endmodule

### src/plb_ctrl.sv
`timescale 1ns / 1ps

module plb_ctrl (
  input  logic [plb_pkg::CMD_W-1:0]        cmd_i,
  input  logic signed [plb_pkg::VAL_W-1:0] value_i,
  input  logic [plb_pkg::POS_W-1:0]        position_i,
  input  logic [plb_pkg::CNT_W-1:0]        count_i,
  output plb_pkg::ctl_t                    ctl_o,
  output plb_pkg::status_e                 status_o,
  output logic [plb_pkg::CNT_W-1:0]        count_o
);
  import plb_pkg::*;

  localparam int unsigned CMP_W = POS_W + CNT_W;

  logic full, empty, pos_lt_cnt;
  logic [CNT_W-1:0] last;

  assign full       = (count_i == CNT_W'(DEPTH));
  assign empty      = (count_i == '0);
  assign last       = count_i - CNT_W'(1);
  assign pos_lt_cnt = (CMP_W'(position_i) < CMP_W'(count_i));

  always_comb begin
    ctl_o.op    = OP_NONE;
    ctl_o.at    = '0;
    ctl_o.value = value_i;
    status_o    = ST_OK;
    count_o     = count_i;
    unique case (cmd_i)
      CMD_APPEND, CMD_INSERT: begin
        if (full) begin
          status_o = ST_FULL;
        end else begin
          ctl_o.op = OP_INSERT;
          // Insert past the end lands on the tail.
          if (cmd_i == CMD_INSERT && pos_lt_cnt) ctl_o.at = IDX_W'(position_i);
          else ctl_o.at = IDX_W'(count_i);
          count_o = count_i + CNT_W'(1);
        end
      end
      CMD_POP, CMD_DEQUEUE, CMD_DELETE: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else if (cmd_i == CMD_DELETE && !pos_lt_cnt) begin
          status_o = ST_RANGE;
        end else begin
          ctl_o.op = OP_REMOVE;
          if (cmd_i == CMD_POP) ctl_o.at = IDX_W'(last);
          else if (cmd_i == CMD_DELETE) ctl_o.at = IDX_W'(position_i);
          else ctl_o.at = '0;
          count_o = last;
        end
      end
      default: ;
    endcase
  end

endmodule

### src/positional_list_buffer_core.sv
`timescale 1ns / 1ps

// Positional list buffer: ordered list of up to DEPTH signed 32-bit values.
// Input channel (in_valid_i / in_stall_o) carries one command item: cmd_i,
// value_i, position_i. Commands: append, insert at position (clamped to the
// tail), pop tail, dequeue head, delete at position.
// Output channel (out_valid_o / out_stall_i) returns one item per command:
// removed value (zero otherwise), status and the length after the command.
// Latency: result is registered, visible the cycle after acceptance.
// Throughput: one item per cycle while in_stall_o is low. Each cell of the chain
// keeps its value or loads its left neighbor, its right neighbor or the new value
// in the same cycle, so the whole list shifts at once.
// Stall: a stalled result holds; a new item is still taken while the
// output register is empty or empties in the same cycle, otherwise in_stall_o is high.
// Reset: list is empty (length zero), output invalid. Entry contents are
// not cleared; only entries below the length are ever read.
module positional_list_buffer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [plb_pkg::CMD_W-1:0]        cmd_i,
  input  logic signed [plb_pkg::VAL_W-1:0] value_i,
  input  logic [plb_pkg::POS_W-1:0]        position_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [plb_pkg::VAL_W-1:0] result_value_o,
  output plb_pkg::status_e                 status_o,
  output logic [plb_pkg::CNT_W-1:0]        length_o
);
  import plb_pkg::*;

  logic                    accept;
  logic                    shift_en;
  ctl_t                    ctl;
  status_e                 status_d, status_q;
  logic [CNT_W-1:0]        count_d, count_q;
  logic [CNT_W-1:0]        length_q;
  logic signed [VAL_W-1:0] result_d, result_q;
  logic                    out_valid_q;

  logic signed [VAL_W-1:0] cell_q   [DEPTH];
  logic [DEPTH-1:0]        cell_hit;

  // Output register frees up when empty or when taken this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign shift_en   = accept && (ctl.op != OP_NONE);

  plb_ctrl u_ctrl (
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .position_i (position_i),
    .count_i    (count_q),
    .ctl_o      (ctl),
    .status_o   (status_d),
    .count_o    (count_d)
  );

  // Chain of cells, head at index 0. Ends feed back their own value.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    plb_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (shift_en),
      .ctl_i   (ctl),
      .idx_i   (IDX_W'(g)),
      .left_i  ((g == 0) ? cell_q[g] : cell_q[(g == 0) ? 0 : g - 1]),
      .right_i ((g == DEPTH - 1) ? cell_q[g] : cell_q[(g == DEPTH - 1) ? g : g + 1]),
      .q_o     (cell_q[g]),
      .hit_o   (cell_hit[g])
    );
  end

  // Removed value: the cell addressed by the command, zero otherwise.
  always_comb begin
    result_d = '0;
    if (ctl.op == OP_REMOVE) begin
      for (int i = 0; i < DEPTH; i++) begin
        result_d = result_d | (cell_hit[i] ? cell_q[i] : '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) count_q <= count_d;
      if (accept) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
      status_q <= status_d;
      length_q <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;
  assign length_o       = length_q;

endmodule

### src/plb_checker.sv
`timescale 1ns / 1ps

module plb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [plb_pkg::VAL_W-1:0] result_value_o,
  input plb_pkg::status_e                 status_o,
  input logic [plb_pkg::CNT_W-1:0]        length_o
);
  import plb_pkg::*;

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (length_o <= CNT_W'(DEPTH)))
    else $error("length beyond depth");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (length_o == CNT_W'(DEPTH)))
    else $error("full status with list not full");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> (length_o == '0))
    else $error("empty status with list not empty");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (result_value_o == '0))
    else $error("error item carries nonzero value");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_value_o)
      && $stable(status_o) && $stable(length_o)))
    else $error("stalled result changed");

endmodule

bind positional_list_buffer_core plb_checker u_plb_checker (.*);

### tb/sv/positional_list_buffer_core_test.sv
`timescale 1ns / 1ps

module positional_list_buffer_core_test;
  import plb_pkg::*;

  // Command codes outside the decoded set; the block treats them as no-ops.
  localparam logic [CMD_W-1:0] CMD_UNUSED5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED7 = 3'd7;

  localparam int STUCK_LIMIT = 2000; // cycles with no transfer on either side
  localparam int HOLD_CYCLES = 250;  // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    status_e                 status;
    logic [CNT_W-1:0]        length;
  } outcome_t;

  // Directed row: rnd draws a fresh value per repeat, fixed means the
  // expected outcome is typed in here instead of taken from the list model.
  typedef struct packed {
    logic [CMD_W-1:0]        c;
    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0]        p;
    int                      reps;
    bit                      rnd;
    bit                      fixed;
    outcome_t                want;
  } step_t;

  localparam outcome_t ANY = '{32'sd0, ST_OK, 5'd0};

  localparam step_t SCRIPT [0:16] = '{
    '{CMD_POP,     32'sd0,        4'd0,  1, 1'b0, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
    '{CMD_DEQUEUE, 32'sd0,        4'd0,  1, 1'b0, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
    '{CMD_DELETE,  32'sd0,        4'd0,  1, 1'b0, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
    '{CMD_UNUSED5, 32'sd5,        4'd3,  1, 1'b0, 1'b1, '{32'sd0, ST_OK, 5'd0}},
    '{CMD_APPEND,  32'h7FFFFFFF,  4'd0,  1, 1'b0, 1'b1, '{32'sd0, ST_OK, 5'd1}},
    '{CMD_APPEND,  32'h80000000,  4'd0,  1, 1'b0, 1'b1, '{32'sd0, ST_OK, 5'd2}},
    '{CMD_INSERT,  -32'sd1,       4'd0,  1, 1'b0, 1'b1, '{32'sd0, ST_OK, 5'd3}},
    // insert past the end lands at the tail
    '{CMD_INSERT,  32'sd0,        4'd15, 1, 1'b0, 1'b1, '{32'sd0, ST_OK, 5'd4}},
    '{CMD_APPEND,  32'sd0,        4'd0, 12, 1'b1, 1'b0, ANY},
    '{CMD_APPEND,  32'sd77,       4'd0,  1, 1'b0, 1'b1, '{32'sd0, ST_FULL, 5'd16}},
    '{CMD_INSERT,  32'sd78,       4'd2,  1, 1'b0, 1'b1, '{32'sd0, ST_FULL, 5'd16}},
    '{CMD_DELETE,  32'sd0,        4'd15, 1, 1'b0, 1'b0, ANY},
    '{CMD_DELETE,  32'sd0,        4'd15, 1, 1'b0, 1'b1, '{32'sd0, ST_RANGE, 5'd15}},
    '{CMD_DELETE,  32'sd0,        4'd1,  1, 1'b0, 1'b1, '{32'h7FFFFFFF, ST_OK, 5'd14}},
    '{CMD_DEQUEUE, 32'sd0,        4'd0,  1, 1'b0, 1'b1, '{-32'sd1, ST_OK, 5'd13}},
    '{CMD_POP,     32'sd0,        4'd0,  1, 1'b0, 1'b0, ANY},
    '{CMD_UNUSED7, -32'sd1,       4'd15, 1, 1'b0, 1'b1, '{32'sd0, ST_OK, 5'd12}}
  };

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [VAL_W-1:0] res_value;
  status_e                 res_status;
  logic [CNT_W-1:0]        res_length;

  // Sideband travelling with each offered item: typed expectation, if any.
  logic     tag_fixed;
  outcome_t tag_want;

  // Knobs set by the stimulus process, read by the receiver.
  int   stall_pct;
  logic hold_go;

  logic signed [VAL_W-1:0] shelf[$];   // list contents, head first
  outcome_t                owed[$];    // outcomes not yet returned
  int errors = 0;
  int n_cmds = 0, n_results = 0, n_full = 0, n_empty = 0, n_range = 0;
  int peak_len = 0;

  always #6 clk = ~clk;

  positional_list_buffer_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .value_i        (value),
    .position_i     (position),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_value_o (res_value),
    .status_o       (res_status),
    .length_o       (res_length)
  );

  // Applies one command to the list and returns what the block must answer.
  function automatic outcome_t list_apply(logic [CMD_W-1:0] c, logic signed [VAL_W-1:0] v,
                                          logic [POS_W-1:0] p);
    outcome_t o;
    int       at;
    o = '{32'sd0, ST_OK, 5'd0};
    case (c)
      CMD_APPEND, CMD_INSERT: begin
        if (shelf.size() >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          at = shelf.size();
          if (c == CMD_INSERT && p < shelf.size()) at = int'(p);
          shelf.insert(at, v);
        end
      end
      CMD_POP: begin
        if (shelf.size() == 0) o.status = ST_EMPTY;
        else o.value = shelf.pop_back();
      end
      CMD_DEQUEUE: begin
        if (shelf.size() == 0) o.status = ST_EMPTY;
        else o.value = shelf.pop_front();
      end
      CMD_DELETE: begin
        if (shelf.size() == 0) begin
          o.status = ST_EMPTY;
        end else if (p >= shelf.size()) begin
          o.status = ST_RANGE;
        end else begin
          o.value = shelf[p];
          shelf.delete(p);
        end
      end
      default: ;
    endcase
    o.length = CNT_W'(shelf.size());
    return o;
  endfunction

  // Scoreboard: all samples are pre-edge values, so ordering within the
  // step does not matter.
  always @(posedge clk) begin : scoreboard
    outcome_t want;
    outcome_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = list_apply(cmd, value, position);
        if (tag_fixed) want = tag_want;
        owed.push_back(want);
        n_cmds++;
        if (shelf.size() > peak_len) peak_len = shelf.size();
      end
      if (out_valid && !out_stall) begin
        got = '{res_value, res_status, res_length};
        n_results++;
        case (res_status)
          ST_FULL:  n_full++;
          ST_EMPTY: n_empty++;
          ST_RANGE: n_range++;
          default: ;
        endcase
        if (owed.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, got value %0d status %0d length %0d",
                   $time, got.value, got.status, got.length);
        end else begin
          want = owed.pop_front();
          if (got.value !== want.value) begin
            errors++;
            $display("%0t ns: result value expected %0d, got %0d", $time, want.value, got.value);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t ns: status expected %0d, got %0d", $time, want.status, got.status);
          end
          if (got.length !== want.length) begin
            errors++;
            $display("%0t ns: length expected %0d, got %0d", $time, want.length, got.length);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if neither side moves for too long.
  always @(posedge clk) begin : watchdog
    int stuck;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                 $time, STUCK_LIMIT, owed.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid is
  // left high so back-to-back items need no extra assignment.
  task automatic offer(logic [CMD_W-1:0] c, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p,
                       int idle_pct, bit fixed, outcome_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    value     <= v;
    position  <= p;
    tag_fixed <= fixed;
    tag_want  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random traffic in runs that lean toward filling, draining or neither,
  // so the list keeps hitting full and empty. No-op codes are not counted.
  task automatic churn(int n_items, int idle_pct);
    int               sent;
    int               run_left;
    int               lean;
    logic [CMD_W-1:0] c;
    sent = 0;
    run_left = 0;
    lean = 50;
    while (sent < n_items) begin
      if (run_left == 0) begin
        run_left = $urandom_range(12, 40);
        case ($urandom_range(2))
          0: lean = 85;
          1: lean = 15;
          default: lean = 50;
        endcase
      end
      run_left--;
      if ($urandom_range(99) < 3) begin
        c = CMD_W'($urandom_range(CMD_UNUSED5, CMD_UNUSED7));
      end else if ($urandom_range(99) < lean) begin
        c = $urandom_range(1) ? CMD_APPEND : CMD_INSERT;
      end else begin
        case ($urandom_range(2))
          0: c = CMD_POP;
          1: c = CMD_DEQUEUE;
          default: c = CMD_DELETE;
        endcase
      end
      offer(c, $urandom, POS_W'($urandom_range(15)), idle_pct, 1'b0, ANY);
      if (c <= CMD_DELETE) sent++;
    end
  endtask

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    cmd       <= CMD_APPEND;
    value     <= '0;
    position  <= '0;
    tag_fixed <= 1'b0;
    tag_want  <= ANY;
    stall_pct <= 0;
    hold_go   <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list errors, no-op codes, extremes, full-list errors, range error.
    foreach (SCRIPT[i]) begin
      repeat (SCRIPT[i].reps) begin
        offer(SCRIPT[i].c, SCRIPT[i].rnd ? $urandom : SCRIPT[i].v, SCRIPT[i].p, 0,
              SCRIPT[i].fixed, SCRIPT[i].want);
      end
    end

    // Random phases with different idle and stall mixes.
    churn(200, 0);
    churn(200, 57);
    stall_pct <= 57;
    churn(200, 0);
    stall_pct <= 16;
    churn(200, 16);

    // Receiver goes quiet for a long stretch while items keep coming.
    stall_pct <= 0;
    hold_go   <= 1'b1;
    churn(50, 0);

    in_valid <= 1'b0;
    while (owed.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands, checked %0d results, deepest list %0d of %0d.",
             n_cmds, n_results, peak_len, DEPTH);
    $display("Error answers seen: %0d full, %0d empty, %0d out of range; %0d mismatches.",
             n_full, n_empty, n_range, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
